/* rtl/dpcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcw_pkg
// shared widths, event codes, register indexes and the control/status
// structs between the controller and the datapath
// ----------------------------------------------------------------------------
package dpcw_pkg;

   localparam int KIND_W    = 3;
   localparam int TIME_W    = 48;
   localparam int WIDX_W    = 4;
   localparam int WORD_W    = 32;
   localparam int CFG_W     = 24;
   localparam int CSR_IDX_W = 2;

   localparam int RING_WORDS_DEF = 16;

   // event codes
   localparam logic [KIND_W-1:0] KIND_EDGE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RESET   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RECOVER = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_LEVEL = 2'd2;

   localparam logic [CFG_W-1:0]  DEBOUNCE_RESET  = 24'd15000;
   localparam logic [CFG_W-1:0]  MIN_PULSE_RESET = 24'd100000;
   localparam logic              INIT_LEVEL_RESET = 1'b1;
   localparam logic [WORD_W-1:0] BLANK_WORD       = 32'hFFFF_FFFF;

   // controller to datapath
   typedef struct packed {
      logic latch;      // capture the accepted word
      logic scan_init;  // clear recover scan state
      logic rd_en;      // read ring at the sweep address
      logic scan;       // process returned ring data
      logic clear_wr;   // write zero at the sweep address
      logic finish;     // commit the event and load the result
   } dpcw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              out_free;
   } dpcw_sts_type;

endpackage

/* rtl/dpcw_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcw channel interfaces
// request (event word) and response (result word) valid/ready channels
// ----------------------------------------------------------------------------
interface dpcw_req_if import dpcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [TIME_W-1:0] time_us;
   logic [WIDX_W-1:0] word_index;
   logic [WORD_W-1:0] word_value;

   modport source (output valid, kind, time_us, word_index, word_value, input ready);
   modport sink   (input valid, kind, time_us, word_index, word_value, output ready);
endinterface

interface dpcw_rsp_if import dpcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] pulse_total;
   logic              store_valid;
   logic [WIDX_W-1:0] store_slot;
   logic [WORD_W-1:0] store_value;
   logic              blanks_found;

   modport source (output valid, pulse_total, store_valid, store_slot, store_value,
                   blanks_found, input ready);
   modport sink   (input valid, pulse_total, store_valid, store_slot, store_value,
                   blanks_found, output ready);
endinterface

/* rtl/dpcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcw_ctrl
// event sequencer: dispatch, ring clear sweep, recover scan, result hand-off
// ----------------------------------------------------------------------------
module dpcw_ctrl
   import dpcw_pkg::*;
#(
   parameter int RING_WORDS = RING_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dpcw_sts_type                  sts,
   output dpcw_cmd_type                  cmd,
   output logic [$clog2(RING_WORDS)-1:0] sweep_addr
);

   localparam int SLOT_W = $clog2(RING_WORDS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_WORDS - 1);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_EXEC      = 3'd1;
   localparam logic [2:0] S_CLEAR     = 3'd2;
   localparam logic [2:0] S_SCAN      = 3'd3;
   localparam logic [2:0] S_SCAN_LAST = 3'd4;
   localparam logic [2:0] S_FINISH    = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cnt_in = '0;
            case (sts.kind)
               KIND_RESET: state_in = S_CLEAR;
               KIND_RECOVER: begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.scan  = 1'b1;
            if (cnt_ff == LAST_SLOT) begin
               state_in = S_SCAN_LAST;
            end else begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         S_SCAN_LAST: begin
            cmd.scan = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign sweep_addr = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/dpcw_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcw_dp
// datapath: config registers, debounce and pulse count, ring memory with
// blank flags, recover scan and the result register
// ----------------------------------------------------------------------------
module dpcw_dp
   import dpcw_pkg::*;
#(
   parameter int RING_WORDS = RING_WORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // config
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CFG_W-1:0]              csr_wdata,
   // request payload
   input  logic [KIND_W-1:0]             req_kind,
   input  logic [TIME_W-1:0]             req_time_us,
   input  logic [WIDX_W-1:0]             req_word_index,
   input  logic [WORD_W-1:0]             req_word_value,
   // control
   input  dpcw_cmd_type                  cmd,
   input  logic [$clog2(RING_WORDS)-1:0] sweep_addr,
   output dpcw_sts_type                  sts,
   // response
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [WORD_W-1:0]             rsp_pulse_total,
   output logic                          rsp_store_valid,
   output logic [WIDX_W-1:0]             rsp_store_slot,
   output logic [WORD_W-1:0]             rsp_store_value,
   output logic                          rsp_blanks_found
);

   localparam int SLOT_W = $clog2(RING_WORDS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_WORDS - 1);

   // captured word
   logic [KIND_W-1:0] kind_ff;
   logic [TIME_W-1:0] time_ff;
   logic [WIDX_W-1:0] widx_ff;
   logic [WORD_W-1:0] wval_ff;

   // config
   logic [CFG_W-1:0] debounce_ff, debounce_in;
   logic [CFG_W-1:0] min_pulse_ff, min_pulse_in;
   logic             init_level_ff, init_level_in;

   // counter state
   logic [WORD_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0] stored_ff, stored_in;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic              level_ff, level_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              seen_ff, seen_in;

   // ring memory, blank until first write
   logic [WORD_W-1:0]     ring_mem [RING_WORDS];
   logic [RING_WORDS-1:0] vld_ff;
   logic [WORD_W-1:0]     rd_data_ff;
   logic                  rd_vld_ff;
   logic                  rd_tag_ff;
   logic [SLOT_W-1:0]     rd_slot_ff;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   logic [WORD_W-1:0]     mem_wdata;

   // recover scan
   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [WORD_W-1:0] first_ff, first_in;
   logic              found_ff, found_in;
   logic              blanks_ff, blanks_in;
   logic [SLOT_W-1:0] cand_slot_ff, cand_slot_in;
   logic [WORD_W-1:0] cand_count_ff, cand_count_in;

   // result
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] pulse_ff, pulse_in;
   logic              st_valid_ff, st_valid_in;
   logic [WIDX_W-1:0] st_slot_ff, st_slot_in;
   logic [WORD_W-1:0] st_value_ff, st_value_in;
   logic              blk_out_ff, blk_out_in;

   logic [TIME_W-1:0] delta;
   logic              edge_pass, edge_long;
   logic [WORD_W-1:0] rd_word, rd_conv;
   logic              rd_blank, scan_step, hit_mid, hit_wrap;
   logic              flush_hit, idx_ok;

   assign delta     = time_ff - last_time_ff;
   assign edge_pass = delta >= {{(TIME_W-CFG_W){1'b0}}, debounce_ff};
   assign edge_long = delta >= {{(TIME_W-CFG_W){1'b0}}, min_pulse_ff};

   assign rd_word   = rd_vld_ff ? rd_data_ff : BLANK_WORD;
   assign rd_blank  = rd_word == BLANK_WORD;
   assign rd_conv   = rd_blank ? '0 : rd_word;
   assign scan_step = cmd.scan && rd_tag_ff;
   assign hit_mid   = (rd_slot_ff != '0) && !found_ff && (rd_conv <= prev_ff);
   assign hit_wrap  = (rd_slot_ff == LAST_SLOT) && !found_ff && !hit_mid
                      && (first_ff <= rd_conv);

   assign flush_hit = count_ff != stored_ff;
   assign idx_ok    = {3'b000, widx_ff} < 7'(RING_WORDS);

   // ring write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
      if (cmd.clear_wr) begin
         mem_we = 1'b1;
      end else if (scan_step && rd_blank) begin
         mem_we    = 1'b1;
         mem_waddr = rd_slot_ff;
      end else if (cmd.finish && kind_ff == KIND_FLUSH && flush_hit) begin
         mem_we    = 1'b1;
         mem_waddr = next_slot_ff;
         mem_wdata = count_ff;
      end else if (cmd.finish && kind_ff == KIND_LOAD && idx_ok) begin
         mem_we    = 1'b1;
         mem_waddr = SLOT_W'(widx_ff);
         mem_wdata = wval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[sweep_addr];
         rd_vld_ff  <= vld_ff[sweep_addr];
         rd_slot_ff <= sweep_addr;
      end
   end

   // scan state
   always_comb begin
      prev_in       = prev_ff;
      first_in      = first_ff;
      found_in      = found_ff;
      blanks_in     = blanks_ff;
      cand_slot_in  = cand_slot_ff;
      cand_count_in = cand_count_ff;
      if (cmd.scan_init) begin
         found_in  = 1'b0;
         blanks_in = 1'b0;
      end else if (scan_step) begin
         prev_in = rd_conv;
         if (rd_blank) begin
            blanks_in = 1'b1;
         end
         if (rd_slot_ff == '0) begin
            first_in = rd_conv;
         end
         if (hit_mid) begin
            found_in      = 1'b1;
            cand_slot_in  = rd_slot_ff;
            cand_count_in = prev_ff;
         end else if (hit_wrap) begin
            found_in      = 1'b1;
            cand_slot_in  = '0;
            cand_count_in = rd_conv;
         end
      end
   end

   // config and event commit
   always_comb begin
      debounce_in   = debounce_ff;
      min_pulse_in  = min_pulse_ff;
      init_level_in = init_level_ff;
      count_in      = count_ff;
      stored_in     = stored_ff;
      next_slot_in  = next_slot_ff;
      level_in      = level_ff;
      last_time_in  = last_time_ff;
      seen_in       = seen_ff;
      st_valid_in   = 1'b0;
      st_slot_in    = '0;
      st_value_in   = '0;
      blk_out_in    = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE:  debounce_in  = csr_wdata;
            CSR_MIN_PULSE: min_pulse_in = csr_wdata;
            CSR_INIT_LEVEL: begin
               init_level_in = csr_wdata[0];
               if (!seen_ff) begin
                  level_in = csr_wdata[0];
               end
            end
            default: ;
         endcase
      end

      if (cmd.finish) begin
         case (kind_ff)
            KIND_EDGE: begin
               if (!seen_ff) begin
                  seen_in      = 1'b1;
                  level_in     = !level_ff;
                  last_time_in = time_ff;
               end else if (edge_pass) begin
                  level_in     = !level_ff;
                  last_time_in = time_ff;
                  if (!level_ff && edge_long) begin
                     count_in = count_ff + 32'd1;
                  end
               end
            end
            KIND_FLUSH: begin
               if (flush_hit) begin
                  stored_in    = count_ff;
                  next_slot_in = (next_slot_ff == LAST_SLOT) ? '0
                                                             : next_slot_ff + SLOT_W'(1);
                  st_valid_in  = 1'b1;
                  st_slot_in   = WIDX_W'(next_slot_ff);
                  st_value_in  = count_ff;
               end
            end
            KIND_RESET: begin
               count_in     = '0;
               stored_in    = '0;
               next_slot_in = '0;
            end
            KIND_RECOVER: begin
               blk_out_in = blanks_ff;
               if (found_ff) begin
                  count_in     = cand_count_ff;
                  stored_in    = cand_count_ff;
                  next_slot_in = cand_slot_ff;
               end
            end
            default: ;
         endcase
      end
      pulse_in = count_in;
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         min_pulse_ff  <= MIN_PULSE_RESET;
         init_level_ff <= INIT_LEVEL_RESET;
         count_ff      <= '0;
         stored_ff     <= '0;
         next_slot_ff  <= '0;
         level_ff      <= INIT_LEVEL_RESET;
         last_time_ff  <= '0;
         seen_ff       <= 1'b0;
         vld_ff        <= '0;
         rd_tag_ff     <= 1'b0;
         found_ff      <= 1'b0;
         blanks_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         debounce_ff   <= debounce_in;
         min_pulse_ff  <= min_pulse_in;
         init_level_ff <= init_level_in;
         count_ff      <= count_in;
         stored_ff     <= stored_in;
         next_slot_ff  <= next_slot_in;
         level_ff      <= level_in;
         last_time_ff  <= last_time_in;
         seen_ff       <= seen_in;
         if (mem_we) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
         rd_tag_ff     <= cmd.rd_en;
         found_ff      <= found_in;
         blanks_ff     <= blanks_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         time_ff <= req_time_us;
         widx_ff <= req_word_index;
         wval_ff <= req_word_value;
      end
      prev_ff       <= prev_in;
      first_ff      <= first_in;
      cand_slot_ff  <= cand_slot_in;
      cand_count_ff <= cand_count_in;
      if (cmd.finish) begin
         pulse_ff    <= pulse_in;
         st_valid_ff <= st_valid_in;
         st_slot_ff  <= st_slot_in;
         st_value_ff <= st_value_in;
         blk_out_ff  <= blk_out_in;
      end
   end

   assign sts.kind     = kind_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pulse_total  = pulse_ff;
   assign rsp_store_valid  = st_valid_ff;
   assign rsp_store_slot   = st_slot_ff;
   assign rsp_store_value  = st_value_ff;
   assign rsp_blanks_found = blk_out_ff;

endmodule

/* rtl/debounced_pulse_counter_wear_ring.sv */
`timescale 1ns / 1ps
// sequence: edge, flush, load and unknown words go from accept through exec to finish;
//   reset-count first clears the ring (one ring word cleared per cycle) and recover first
//   scans it (one ring word read per cycle through the single read port), then finish
// flow: one word at a time, next word accepted in idle, entered as the result is
//   registered; the result register lets a new word in while the old one waits
// reset: synchronous, active high; config returns to its reset values, all ring words
//   read as blank (all ones) through per-word flags, no clearing pass
// ----------------------------------------------------------------------------
// debounced_pulse_counter_wear_ring
// debounced switch pulse counter with a wear-levelled ring of stored counts
// ----------------------------------------------------------------------------
module debounced_pulse_counter_wear_ring
   import dpcw_pkg::*;
#(
   parameter int RING_WORDS = RING_WORDS_DEF   // ring depth, 2 to 16
) (
   input  logic                 clock,
   input  logic                 reset,
   dpcw_req_if.sink             req_if,
   dpcw_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int SLOT_W = $clog2(RING_WORDS);

   // command and status between sequencer and datapath
   dpcw_cmd_type      cmd;
   dpcw_sts_type      sts;
   logic [SLOT_W-1:0] sweep_addr;

   // sequencer: takes a word in idle, dispatches on its kind, runs the
   // ring sweeps and hands the result off once the output register frees
   dpcw_ctrl #(
      .RING_WORDS (RING_WORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .sts        (sts),
      .cmd        (cmd),
      .sweep_addr (sweep_addr)
   );

   // datapath: holds every piece of architectural state and the result word
   dpcw_dp #(
      .RING_WORDS (RING_WORDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_if.kind),
      .req_time_us      (req_if.time_us),
      .req_word_index   (req_if.word_index),
      .req_word_value   (req_if.word_value),
      .cmd              (cmd),
      .sweep_addr       (sweep_addr),
      .sts              (sts),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_pulse_total  (rsp_if.pulse_total),
      .rsp_store_valid  (rsp_if.store_valid),
      .rsp_store_slot   (rsp_if.store_slot),
      .rsp_store_value  (rsp_if.store_value),
      .rsp_blanks_found (rsp_if.blanks_found)
   );

   // result is only committed when the output register can take it
   a_finish_free : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> sts.out_free)
      else $error("result committed while output register busy");

   // one word in flight: no accept right after an accept
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("second word accepted while busy");

   // a committed event always shows up on the response channel
   a_finish_rsp : assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_if.valid)
      else $error("committed result not presented");

   // clear sweep and recover scan share the sweep address
   a_sweep_excl : assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_wr && cmd.scan))
      else $error("clear sweep and recover scan overlap");

endmodule
